// File: design/buzzer_tune_sequencer_unit_macros.svh
// ----------------------------------------------------------------------------
// Buzzer tune sequencer assertion macros
// Shorthand for clocked, reset-qualified concurrent assertions.
// ----------------------------------------------------------------------------
`ifndef BUZZER_TUNE_SEQUENCER_UNIT_MACROS_SVH
`define BUZZER_TUNE_SEQUENCER_UNIT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define BTS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define BTS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/bts_pkg.sv
// ----------------------------------------------------------------------------
// Buzzer tune sequencer package
// Codes, constants, note type and the fixed tune ROM.
// ----------------------------------------------------------------------------
package bts_pkg;

  // Item function codes.
  localparam logic [1:0] FUNC_STORE = 2'd0;
  localparam logic [1:0] FUNC_START = 2'd1;
  localparam logic [1:0] FUNC_NEXT  = 2'd2;

  // Result status codes.
  localparam logic [1:0] ST_LOADED   = 2'd0;
  localparam logic [1:0] ST_FINISHED = 2'd1;
  localparam logic [1:0] ST_INVALID  = 2'd2;
  localparam logic [1:0] ST_STORED   = 2'd3;

  // Tune identifiers.
  localparam logic [2:0] TUNE_JINGLE    = 3'd0;
  localparam logic [2:0] TUNE_ON        = 3'd1;
  localparam logic [2:0] TUNE_OFF       = 3'd2;
  localparam logic [2:0] TUNE_PRECHARGE = 3'd3;
  localparam logic [2:0] TUNE_FIX       = 3'd4;
  localparam logic [2:0] TUNE_RAM       = 3'd5;

  // Arithmetic constants.
  localparam int unsigned RamNotesDef = 128;
  localparam logic [21:0] TickClock   = 22'd4000000;
  localparam logic [21:0] PausePeriod = 22'd4000;

  // Dividing by 1000 is a shift by three and then a multiply by
  // ceil(2^36 / 125) followed by a shift by 36; exact for any 32-bit product.
  localparam logic [29:0] MsRecip      = 30'd549755814;
  localparam int unsigned MsRecipShift = 36;

  typedef struct packed {
    logic [15:0] ms;
    logic [15:0] freq;
  } note_t;

  // Number of notes in each ROM tune.
  function automatic logic [7:0] rom_length(input logic [2:0] tune);
    logic [7:0] len;
    case (tune)
      TUNE_JINGLE:    len = 8'd11;
      TUNE_ON:        len = 8'd3;
      TUNE_OFF:       len = 8'd3;
      TUNE_PRECHARGE: len = 8'd5;
      TUNE_FIX:       len = 8'd7;
      default:        len = 8'd0;
    endcase
    return len;
  endfunction

  // ROM note lookup; frequencies are the octave-shifted base pitches.
  function automatic note_t rom_note(input logic [2:0] tune, input logic [3:0] pos);
    note_t n;
    n = '0;
    case (tune)
      TUNE_JINGLE: begin
        case (pos)
          4'd0:    n = '{ms: 16'd38,  freq: 16'd10548};
          4'd1:    n = '{ms: 16'd45,  freq: 16'd8870};
          4'd2:    n = '{ms: 16'd55,  freq: 16'd7458};
          4'd3:    n = '{ms: 16'd58,  freq: 16'd7040};
          4'd4:    n = '{ms: 16'd63,  freq: 16'd6272};
          4'd5:    n = '{ms: 16'd68,  freq: 16'd5920};
          4'd6:    n = '{ms: 16'd75,  freq: 16'd5274};
          4'd7:    n = '{ms: 16'd85,  freq: 16'd4698};
          4'd8:    n = '{ms: 16'd95,  freq: 16'd4186};
          4'd9:    n = '{ms: 16'd105, freq: 16'd3951};
          4'd10:   n = '{ms: 16'd113, freq: 16'd3520};
          default: n = '0;
        endcase
      end
      TUNE_ON: begin
        case (pos)
          4'd0:    n = '{ms: 16'd75,  freq: 16'd5274};
          4'd1:    n = '{ms: 16'd113, freq: 16'd3520};
          4'd2:    n = '{ms: 16'd113, freq: 16'd3520};
          default: n = '0;
        endcase
      end
      TUNE_OFF: begin
        case (pos)
          4'd0:    n = '{ms: 16'd75,  freq: 16'd3520};
          4'd1:    n = '{ms: 16'd113, freq: 16'd3520};
          4'd2:    n = '{ms: 16'd75,  freq: 16'd5274};
          default: n = '0;
        endcase
      end
      TUNE_PRECHARGE: begin
        case (pos)
          4'd0:    n = '{ms: 16'd25,  freq: 16'd7040};
          4'd1:    n = '{ms: 16'd95,  freq: 16'd3520};
          4'd2:    n = '{ms: 16'd40,  freq: 16'd0};
          4'd3:    n = '{ms: 16'd25,  freq: 16'd7040};
          4'd4:    n = '{ms: 16'd175, freq: 16'd3520};
          default: n = '0;
        endcase
      end
      TUNE_FIX: begin
        case (pos)
          4'd0:    n = '{ms: 16'd110, freq: 16'd880};
          4'd1:    n = '{ms: 16'd110, freq: 16'd1975};
          4'd2:    n = '{ms: 16'd110, freq: 16'd2093};
          4'd3:    n = '{ms: 16'd100, freq: 16'd3136};
          4'd4:    n = '{ms: 16'd100, freq: 16'd0};
          4'd5:    n = '{ms: 16'd25,  freq: 16'd4186};
          4'd6:    n = '{ms: 16'd195, freq: 16'd2093};
          default: n = '0;
        endcase
      end
      default: n = '0;
    endcase
    return n;
  endfunction

endpackage

// File: design/buzzer_tune_sequencer_unit.sv
// ----------------------------------------------------------------------------
// Buzzer tune sequencer unit
// Store, invalid and bad-id items answer in the cycle after start; end of
// tune and missing tune answer from the advance state; a pause from the
// calc state, after the RAM read state for the RAM tune. A tone goes through
// a 1-bit-per-cycle divider running 22 steps for the period; the repeat count
// comes from a reciprocal multiply. One item at a time; results cannot stall.
// Reset clears control state, the tune length and all RAM valid bits at once.
// ----------------------------------------------------------------------------
module buzzer_tune_sequencer_unit
  import bts_pkg::*;
#(
  parameter int unsigned RAM_NOTES = RamNotesDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item command port
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  func_i,
  input  logic [2:0]  tune_id_i,
  input  logic [6:0]  note_index_i,
  input  logic [15:0] note_freq_i,
  input  logic [15:0] note_length_ms_i,
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [7:0]  cfg_data_i,
  // Result strobe and payload
  output logic        result_valid_o,
  output logic [1:0]  status_o,
  output logic [21:0] period_ticks_o,
  output logic [21:0] compare_ticks_o,
  output logic [22:0] repeat_count_o
);

  localparam int unsigned RamAw     = (RAM_NOTES > 1) ? $clog2(RAM_NOTES) : 1;
  localparam logic [7:0]  RamNotesW = 8'(RAM_NOTES);
  localparam int unsigned PerW      = 22;
  localparam logic [4:0]  PerLast   = 5'(PerW - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADVANCE,
    S_RD,
    S_CALC,
    S_DIV_PER
  } state_e;

  state_e                 state_q, state_d;
  logic [2:0]             active_tune_q, active_tune_d;
  logic                   tune_active_q, tune_active_d;
  logic [7:0]             pos_q, pos_d;
  logic [7:0]             ram_len_q, ram_len_d;
  logic [RAM_NOTES-1:0]   ram_vld_q, ram_vld_d;
  logic                   rd_hit_q, rd_hit_d;
  logic [15:0]            freq_q, freq_d;
  logic [15:0]            ms_q, ms_d;
  logic [31:0]            prod_q, prod_d;
  logic [PerW-1:0]        dvd_q, dvd_d;
  logic [15:0]            rem_q, rem_d;
  logic [4:0]             cnt_q, cnt_d;
  logic                   res_vld_q, res_vld_d;
  logic [1:0]             status_q, status_d;
  logic [21:0]            per_out_q, per_out_d;
  logic [21:0]            cmp_out_q, cmp_out_d;
  logic [22:0]            rep_out_q, rep_out_d;

  // RAM tune storage
  logic [31:0]            ram_q [RAM_NOTES];
  logic [31:0]            rd_data_q;
  logic                   mem_we;
  logic                   mem_re;
  logic [7:0]             slot_ext;
  logic [RamAw-1:0]       wr_addr;
  logic [RamAw-1:0]       rd_addr;
  logic                   wr_ok;

  // Divider step and helpers
  logic [16:0]            rem_sh;
  logic [17:0]            sub;
  logic                   q_bit;
  logic [15:0]            rem_nx;
  logic [PerW-1:0]        dvd_nx;
  logic [31:0]            prod_w;
  logic [58:0]            rep_prod;
  logic [7:0]             ram_len_eff;
  logic [7:0]             tune_len;
  note_t                  rom_n;

  assign busy        = (state_q != S_IDLE);
  assign cfg_ready_o = !busy;

  // Write and read addresses of the note RAM.
  assign slot_ext = {1'b0, note_index_i};
  assign wr_ok    = (slot_ext < RamNotesW);
  assign wr_addr  = slot_ext[RamAw-1:0];
  assign rd_addr  = pos_q[RamAw-1:0];

  // One restoring division step: shift in a dividend bit, try to subtract.
  assign rem_sh = {rem_q, dvd_q[PerW-1]};
  assign sub    = {1'b0, rem_sh} - {2'b00, freq_q};
  assign q_bit  = !sub[17];
  assign rem_nx = q_bit ? sub[15:0] : rem_sh[15:0];
  assign dvd_nx = {dvd_q[PerW-2:0], q_bit};

  // Frequency times duration, registered before the reciprocal multiply.
  assign prod_w = freq_q * ms_q;

  // Repeat count: the registered product divided by 1000.
  assign rep_prod = prod_q[31:3] * MsRecip;

  // Length of the active tune; the RAM length is capped at the store depth.
  assign ram_len_eff = (ram_len_q > RamNotesW) ? RamNotesW : ram_len_q;
  assign tune_len    = (active_tune_q == TUNE_RAM) ? ram_len_eff : rom_length(active_tune_q);
  assign rom_n       = rom_note(active_tune_q, pos_q[3:0]);

  // Sequencer next-state logic.
  always_comb begin
    state_d       = state_q;
    active_tune_d = active_tune_q;
    tune_active_d = tune_active_q;
    pos_d         = pos_q;
    ram_len_d     = ram_len_q;
    ram_vld_d     = ram_vld_q;
    rd_hit_d      = rd_hit_q;
    freq_d        = freq_q;
    ms_d          = ms_q;
    prod_d        = prod_q;
    dvd_d         = dvd_q;
    rem_d         = rem_q;
    cnt_d         = cnt_q;
    res_vld_d     = 1'b0;
    status_d      = status_q;
    per_out_d     = per_out_q;
    cmp_out_d     = cmp_out_q;
    rep_out_d     = rep_out_q;
    mem_we        = 1'b0;
    mem_re        = 1'b0;

    if (cfg_valid_i && cfg_ready_o) begin
      ram_len_d = cfg_data_i;
    end

    case (state_q)
      S_IDLE: begin
        if (start) begin
          per_out_d = '0;
          cmp_out_d = '0;
          rep_out_d = '0;
          case (func_i)
            FUNC_STORE: begin
              mem_we = wr_ok;
              if (wr_ok) begin
                ram_vld_d[wr_addr] = 1'b1;
              end
              res_vld_d = 1'b1;
              status_d  = ST_STORED;
            end
            FUNC_START: begin
              if (tune_id_i > TUNE_RAM) begin
                res_vld_d = 1'b1;
                status_d  = ST_INVALID;
              end else begin
                active_tune_d = tune_id_i;
                tune_active_d = 1'b1;
                pos_d         = '0;
                state_d       = S_ADVANCE;
              end
            end
            FUNC_NEXT: begin
              state_d = S_ADVANCE;
            end
            default: begin
              res_vld_d = 1'b1;
              status_d  = ST_INVALID;
            end
          endcase
        end
      end
      S_ADVANCE: begin
        if (!tune_active_q) begin
          res_vld_d = 1'b1;
          status_d  = ST_INVALID;
          state_d   = S_IDLE;
        end else if (pos_q >= tune_len) begin
          res_vld_d = 1'b1;
          status_d  = ST_FINISHED;
          state_d   = S_IDLE;
        end else begin
          pos_d = pos_q + 8'd1;
          if (active_tune_q == TUNE_RAM) begin
            mem_re   = 1'b1;
            rd_hit_d = ram_vld_q[rd_addr];
            state_d  = S_RD;
          end else begin
            freq_d  = rom_n.freq;
            ms_d    = rom_n.ms;
            state_d = S_CALC;
          end
        end
      end
      S_RD: begin
        // An entry never written reads as a zero note.
        freq_d  = rd_hit_q ? rd_data_q[15:0] : '0;
        ms_d    = rd_hit_q ? rd_data_q[31:16] : '0;
        state_d = S_CALC;
      end
      S_CALC: begin
        if (freq_q == '0) begin
          res_vld_d = 1'b1;
          status_d  = ST_LOADED;
          per_out_d = PausePeriod;
          cmp_out_d = PausePeriod;
          rep_out_d = {7'd0, ms_q};
          state_d   = S_IDLE;
        end else begin
          prod_d  = prod_w;
          dvd_d   = TickClock;
          rem_d   = '0;
          cnt_d   = PerLast;
          state_d = S_DIV_PER;
        end
      end
      S_DIV_PER: begin
        dvd_d = dvd_nx;
        rem_d = rem_nx;
        cnt_d = cnt_q - 5'd1;
        if (cnt_q == '0) begin
          res_vld_d = 1'b1;
          status_d  = ST_LOADED;
          per_out_d = dvd_nx;
          cmp_out_d = {1'b0, dvd_nx[PerW-1:1]};
          rep_out_d = rep_prod[MsRecipShift+22:MsRecipShift];
          state_d   = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State, playback registers and the registered result.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= S_IDLE;
      active_tune_q <= '0;
      tune_active_q <= 1'b0;
      pos_q         <= '0;
      ram_len_q     <= '0;
      ram_vld_q     <= '0;
      rd_hit_q      <= 1'b0;
      freq_q        <= '0;
      ms_q          <= '0;
      prod_q        <= '0;
      dvd_q         <= '0;
      rem_q         <= '0;
      cnt_q         <= '0;
      res_vld_q     <= 1'b0;
      status_q      <= '0;
      per_out_q     <= '0;
      cmp_out_q     <= '0;
      rep_out_q     <= '0;
    end else begin
      state_q       <= state_d;
      active_tune_q <= active_tune_d;
      tune_active_q <= tune_active_d;
      pos_q         <= pos_d;
      ram_len_q     <= ram_len_d;
      ram_vld_q     <= ram_vld_d;
      rd_hit_q      <= rd_hit_d;
      freq_q        <= freq_d;
      ms_q          <= ms_d;
      prod_q        <= prod_d;
      dvd_q         <= dvd_d;
      rem_q         <= rem_d;
      cnt_q         <= cnt_d;
      res_vld_q     <= res_vld_d;
      status_q      <= status_d;
      per_out_q     <= per_out_d;
      cmp_out_q     <= cmp_out_d;
      rep_out_q     <= rep_out_d;
    end
  end

  // Note RAM: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      ram_q[wr_addr] <= {note_length_ms_i, note_freq_i};
    end
    if (mem_re) begin
      rd_data_q <= ram_q[rd_addr];
    end
  end

  assign result_valid_o  = res_vld_q;
  assign status_o        = status_q;
  assign period_ticks_o  = per_out_q;
  assign compare_ticks_o = cmp_out_q;
  assign repeat_count_o  = rep_out_q;

endmodule

// File: design/bts_checker.sv
// ----------------------------------------------------------------------------
// Buzzer tune sequencer port checker
// Watches the top-level ports for result and handshake consistency.
// ----------------------------------------------------------------------------
`include "buzzer_tune_sequencer_unit_macros.svh"

module bts_checker
  import bts_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [1:0]  func_i,
  input logic [2:0]  tune_id_i,
  input logic        result_valid_o,
  input logic [1:0]  status_o,
  input logic [21:0] period_ticks_o,
  input logic [21:0] compare_ticks_o,
  input logic [22:0] repeat_count_o
);

  // A result beat always leaves the unit ready for the next item.
  `BTS_ASSERT_SAME(a_res_not_busy, result_valid_o, !busy, "result beat while busy")

  // Only a loaded note carries a PWM setting.
  `BTS_ASSERT_SAME(a_res_zero_fields, result_valid_o && (status_o != ST_LOADED), (period_ticks_o == '0) && (compare_ticks_o == '0) && (repeat_count_o == '0), "nonzero fields without a loaded note")

  // The compare value is half the period, or the full pause period.
  `BTS_ASSERT_SAME(a_res_compare, result_valid_o && (status_o == ST_LOADED), (compare_ticks_o == (period_ticks_o >> 1)) || ((period_ticks_o == PausePeriod) && (compare_ticks_o == PausePeriod)), "compare value does not match period")

  // A start with a bad tune id is rejected in the very next cycle.
  `BTS_ASSERT_NEXT(a_bad_id, start && !busy && (func_i == FUNC_START) && (tune_id_i > TUNE_RAM), result_valid_o && (status_o == ST_INVALID), "bad tune id not rejected")

endmodule

bind buzzer_tune_sequencer_unit bts_checker u_bts_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .func_i         (func_i),
  .tune_id_i      (tune_id_i),
  .result_valid_o (result_valid_o),
  .status_o       (status_o),
  .period_ticks_o (period_ticks_o),
  .compare_ticks_o(compare_ticks_o),
  .repeat_count_o (repeat_count_o)
);

// File: bench/bts_note_checker.sv
// ----------------------------------------------------------------------------
// Buzzer tune sequencer result checker
// Watches the item, configuration and result channels of the sequencer. It
// keeps its own copy of the note RAM, the tune length and the playback
// position, and works out the PWM setting for every accepted item. Each
// result beat is compared field by field with the oldest setting waiting.
// ----------------------------------------------------------------------------
module bts_note_checker
  import bts_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  // Item command port
  input  logic        start_i,
  input  logic        busy_i,
  input  logic [1:0]  func_i,
  input  logic [2:0]  tune_id_i,
  input  logic [6:0]  note_index_i,
  input  logic [15:0] note_freq_i,
  input  logic [15:0] note_length_ms_i,
  // Configuration write channel
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [7:0]  cfg_data_i,
  // Result strobe and payload
  input  logic        result_valid_i,
  input  logic [1:0]  status_i,
  input  logic [21:0] period_ticks_i,
  input  logic [21:0] compare_ticks_i,
  input  logic [22:0] repeat_count_i,
  // Results still owed and mismatches seen so far
  output int          pending_o,
  output int          fail_count_o
);

  localparam int unsigned NoteSlots  = 128;
  localparam logic [31:0] TicksPerSec = 32'd4000000;
  localparam logic [21:0] RestTicks   = 22'd4000;
  localparam logic [31:0] MsPerSecond = 32'd1000;

  typedef struct packed {
    logic [1:0]  status;
    logic [21:0] period;
    logic [21:0] cmp;
    logic [22:0] reps;
  } pwm_setting_t;

  // Model state: RAM words hold the duration in the upper half and the
  // frequency in the lower half.
  logic [31:0]  tune_words [NoteSlots];
  logic [2:0]   cur_tune;
  logic         playing;
  logic [7:0]   note_pos;
  logic [7:0]   ram_len;
  pwm_setting_t expected_settings [$];
  int           n_fail = 0;

  assign fail_count_o = n_fail;

  // Print one line per mismatch and count it.
  task automatic report_mismatch(input string what, input logic [31:0] want,
                                 input logic [31:0] got);
    $display("mismatch at %0t: %s expected %0d got %0d", $realtime, what, want, got);
    n_fail++;
  endtask

  // A fixed tune note: a base pitch shifted down by nine minus the octave.
  function automatic logic [31:0] tone(input int unsigned base, input int unsigned oct,
                                       input int unsigned ms);
    logic [31:0] pitch;
    pitch = base >> (9 - oct);
    return {ms[15:0], pitch[15:0]};
  endfunction

  // Note word of a fixed tune at a given position.
  function automatic logic [31:0] rom_word(input logic [2:0] tune, input logic [7:0] pos);
    logic [31:0] w;
    w = '0;
    case (tune)
      TUNE_JINGLE: begin
        case (pos)
          8'd0:  w = tone(10548, 9, 38);
          8'd1:  w = tone(8870, 9, 45);
          8'd2:  w = tone(14917, 8, 55);
          8'd3:  w = tone(14080, 8, 58);
          8'd4:  w = tone(12544, 8, 63);
          8'd5:  w = tone(11840, 8, 68);
          8'd6:  w = tone(10548, 8, 75);
          8'd7:  w = tone(9397, 8, 85);
          8'd8:  w = tone(8372, 8, 95);
          8'd9:  w = tone(15804, 7, 105);
          8'd10: w = tone(14080, 7, 113);
          default: w = '0;
        endcase
      end
      TUNE_ON: begin
        case (pos)
          8'd0:  w = tone(10548, 8, 75);
          8'd1:  w = tone(14080, 7, 113);
          8'd2:  w = tone(14080, 7, 113);
          default: w = '0;
        endcase
      end
      TUNE_OFF: begin
        case (pos)
          8'd0:  w = tone(14080, 7, 75);
          8'd1:  w = tone(14080, 7, 113);
          8'd2:  w = tone(10548, 8, 75);
          default: w = '0;
        endcase
      end
      TUNE_PRECHARGE: begin
        case (pos)
          8'd0:  w = tone(14080, 8, 25);
          8'd1:  w = tone(14080, 7, 95);
          8'd2:  w = tone(0, 9, 40);
          8'd3:  w = tone(14080, 8, 25);
          8'd4:  w = tone(14080, 7, 175);
          default: w = '0;
        endcase
      end
      TUNE_FIX: begin
        case (pos)
          8'd0:  w = tone(14080, 5, 110);
          8'd1:  w = tone(15804, 6, 110);
          8'd2:  w = tone(8372, 7, 110);
          8'd3:  w = tone(12544, 7, 100);
          8'd4:  w = tone(0, 9, 100);
          8'd5:  w = tone(8372, 8, 25);
          8'd6:  w = tone(8372, 7, 195);
          default: w = '0;
        endcase
      end
      default: w = '0;
    endcase
    return w;
  endfunction

  // Number of notes in a fixed tune.
  function automatic logic [7:0] rom_tune_len(input logic [2:0] tune);
    logic [7:0] len;
    case (tune)
      TUNE_JINGLE:    len = 8'd11;
      TUNE_ON:        len = 8'd3;
      TUNE_OFF:       len = 8'd3;
      TUNE_PRECHARGE: len = 8'd5;
      TUNE_FIX:       len = 8'd7;
      default:        len = 8'd0;
    endcase
    return len;
  endfunction

  // Load the next note of the active tune and step past it.
  function automatic pwm_setting_t fetch_note();
    pwm_setting_t s;
    logic [7:0]   len;
    logic [31:0]  word;
    logic [31:0]  freq;
    logic [31:0]  ms;
    logic [31:0]  per;
    logic [31:0]  cycles;
    s = '0;
    if (cur_tune == TUNE_RAM) begin
      len = (ram_len > NoteSlots[7:0]) ? NoteSlots[7:0] : ram_len;
    end else begin
      len = rom_tune_len(cur_tune);
    end
    if (!playing) begin
      s.status = ST_INVALID;
    end else if (note_pos >= len) begin
      s.status = ST_FINISHED;
    end else begin
      word = (cur_tune == TUNE_RAM) ? tune_words[note_pos[6:0]] : rom_word(cur_tune, note_pos);
      freq = {16'd0, word[15:0]};
      ms   = {16'd0, word[31:16]};
      s.status = ST_LOADED;
      if (freq == 32'd0) begin
        // A rest sets the compare value equal to the whole period.
        s.period = RestTicks;
        s.cmp    = RestTicks;
        s.reps   = ms[22:0];
      end else begin
        per    = TicksPerSec / freq;
        cycles = (freq * ms) / MsPerSecond;
        s.period = per[21:0];
        s.cmp    = per[22:1];
        s.reps   = cycles[22:0];
      end
      note_pos = note_pos + 8'd1;
    end
    return s;
  endfunction

  // Apply one item to the model state and return the setting it answers with.
  function automatic pwm_setting_t predict_item(input logic [1:0] f, input logic [2:0] id,
                                                input logic [6:0] slot,
                                                input logic [15:0] freq,
                                                input logic [15:0] ms);
    pwm_setting_t s;
    s = '0;
    case (f)
      FUNC_STORE: begin
        tune_words[slot] = {ms, freq};
        s.status = ST_STORED;
      end
      FUNC_START: begin
        if (id > TUNE_RAM) begin
          s.status = ST_INVALID;
        end else begin
          cur_tune = id;
          playing  = 1'b1;
          note_pos = 8'd0;
          s = fetch_note();
        end
      end
      FUNC_NEXT: s = fetch_note();
      default:   s.status = ST_INVALID;
    endcase
    return s;
  endfunction

  // Retire results first, then take configuration and item beats.
  always @(posedge clk_i) begin
    pwm_setting_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NoteSlots; i++) begin
        tune_words[i] = '0;
      end
      cur_tune = TUNE_JINGLE;
      playing  = 1'b0;
      note_pos = 8'd0;
      ram_len  = 8'd0;
      expected_settings.delete();
      pending_o <= 0;
    end else begin
      if (result_valid_i) begin
        if (expected_settings.size() == 0) begin
          report_mismatch("result beat with nothing owed, status", '0, status_i);
        end else begin
          want = expected_settings.pop_front();
          if (status_i !== want.status) begin
            report_mismatch("status", want.status, status_i);
          end
          if (period_ticks_i !== want.period) begin
            report_mismatch("period_ticks", want.period, period_ticks_i);
          end
          if (compare_ticks_i !== want.cmp) begin
            report_mismatch("compare_ticks", want.cmp, compare_ticks_i);
          end
          if (repeat_count_i !== want.reps) begin
            report_mismatch("repeat_count", want.reps, repeat_count_i);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        ram_len = cfg_data_i;
      end
      if (start_i && !busy_i) begin
        expected_settings.push_back(predict_item(func_i, tune_id_i, note_index_i,
                                                 note_freq_i, note_length_ms_i));
      end
      pending_o <= expected_settings.size();
    end
  end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// Buzzer tune sequencer testbench
// Drives directed and random item beats into the sequencer, rewrites the RAM
// tune length between phases, and leaves prediction and comparison to the
// checker. The verdict comes from the checker's mismatch count and a
// watchdog on cycles without any accepted beat.
// ----------------------------------------------------------------------------
module tb;
  import bts_pkg::*;

  localparam int ItemTarget  = 1800;
  localparam int CalmTail    = 200;
  localparam int PhaseItems  = 60;
  localparam int StallLimit  = 2000;
  localparam int DrainCycles = 64;

  // Codes the package leaves unnamed.
  localparam logic [1:0] FuncUnused = 2'd3;
  localparam logic [2:0] TuneBadLo  = 3'd6;
  localparam logic [2:0] TuneBadHi  = 3'd7;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  item_func = '0;
  logic [2:0]  item_tune = '0;
  logic [6:0]  item_slot = '0;
  logic [15:0] item_freq = '0;
  logic [15:0] item_ms = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [7:0]  cfg_data = '0;
  logic        result_valid;
  logic [1:0]  status;
  logic [21:0] period_ticks;
  logic [21:0] compare_ticks;
  logic [22:0] repeat_count;
  int          pending;
  int          fail_count;
  int          items_sent = 0;
  bit          idle_phase = 1'b0;
  int          stall_cycles = 0;

  always #2 clk_i = ~clk_i;

  buzzer_tune_sequencer_unit u_dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .func_i           (item_func),
    .tune_id_i        (item_tune),
    .note_index_i     (item_slot),
    .note_freq_i      (item_freq),
    .note_length_ms_i (item_ms),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .result_valid_o   (result_valid),
    .status_o         (status),
    .period_ticks_o   (period_ticks),
    .compare_ticks_o  (compare_ticks),
    .repeat_count_o   (repeat_count)
  );

  bts_note_checker u_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start_i          (start),
    .busy_i           (busy),
    .func_i           (item_func),
    .tune_id_i        (item_tune),
    .note_index_i     (item_slot),
    .note_freq_i      (item_freq),
    .note_length_ms_i (item_ms),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_i      (cfg_ready),
    .cfg_data_i       (cfg_data),
    .result_valid_i   (result_valid),
    .status_i         (status),
    .period_ticks_i   (period_ticks),
    .compare_ticks_i  (compare_ticks),
    .repeat_count_i   (repeat_count),
    .pending_o        (pending),
    .fail_count_o     (fail_count)
  );

  // Watchdog: too long without any beat on any channel ends the run.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((start && !busy) || result_valid || (cfg_valid && cfg_ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("simulation failed");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  // Present one item, after an optional idle burst, until the unit takes it.
  task automatic send_item(input logic [1:0] f, input logic [2:0] id, input logic [6:0] slot,
                           input logic [15:0] freq, input logic [15:0] ms);
    int gap;
    gap = 0;
    if (idle_phase && items_sent < ItemTarget - CalmTail && $urandom_range(0, 3) == 0) begin
      gap = $urandom_range(1, 13);
    end
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start     <= 1'b1;
    item_func <= f;
    item_tune <= id;
    item_slot <= slot;
    item_freq <= freq;
    item_ms   <= ms;
    do @(posedge clk_i); while (busy);
    items_sent++;
  endtask

  // Stop sending and wait until every owed result has come back.
  task automatic wait_idle();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  // One beat on the configuration channel.
  task automatic write_length(input logic [7:0] len);
    cfg_valid <= 1'b1;
    cfg_data  <= len;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // Frequencies weighted toward rests, the extremes and audible tones.
  function automatic logic [15:0] pick_freq();
    case ($urandom_range(0, 7))
      0:       return 16'd0;
      1:       return 16'd1;
      2:       return 16'hFFFF;
      3, 4:    return 16'($urandom_range(20, 20000));
      5:       return 16'($urandom_range(1, 255));
      default: return 16'($urandom);
    endcase
  endfunction

  // Durations weighted toward the extremes and short notes.
  function automatic logic [15:0] pick_ms();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2, 3:    return 16'($urandom_range(1, 500));
      default: return 16'($urandom);
    endcase
  endfunction

  // Stimulus: directed items, then random phases with a fresh tune length.
  initial begin
    logic [7:0] cur_len;
    int         eff_len;
    int         n_notes;
    int         plays;
    int         phase_end;

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // No tune yet, the unused function code and both bad tune ids.
    send_item(FUNC_NEXT, TUNE_JINGLE, 7'd0, 16'd0, 16'd0);
    send_item(FuncUnused, TUNE_RAM, 7'h7F, 16'hFFFF, 16'hFFFF);
    send_item(FUNC_START, TuneBadLo, 7'd0, 16'd0, 16'd0);
    send_item(FUNC_START, TuneBadHi, 7'h7F, 16'hFFFF, 16'hFFFF);
    // An empty RAM tune ends at once and keeps reporting the end.
    send_item(FUNC_START, TUNE_RAM, 7'd0, 16'd0, 16'd0);
    send_item(FUNC_NEXT, TUNE_RAM, 7'd0, 16'd0, 16'd0);
    // The first note of every fixed tune.
    send_item(FUNC_START, TUNE_JINGLE, 7'd0, 16'd0, 16'd0);
    send_item(FUNC_START, TUNE_ON, 7'd0, 16'd0, 16'd0);
    send_item(FUNC_START, TUNE_OFF, 7'd0, 16'd0, 16'd0);
    send_item(FUNC_START, TUNE_PRECHARGE, 7'd0, 16'd0, 16'd0);
    send_item(FUNC_START, TUNE_FIX, 7'd0, 16'd0, 16'd0);
    send_item(FUNC_NEXT, TUNE_FIX, 7'd0, 16'd0, 16'd0);
    // Stored notes at the field extremes.
    send_item(FUNC_STORE, TUNE_JINGLE, 7'd0, 16'd0, 16'd0);
    send_item(FUNC_STORE, TUNE_JINGLE, 7'd1, 16'd1, 16'hFFFF);
    send_item(FUNC_STORE, TUNE_JINGLE, 7'd2, 16'hFFFF, 16'd0);
    send_item(FUNC_STORE, TUNE_JINGLE, 7'd3, 16'hFFFF, 16'hFFFF);
    send_item(FUNC_STORE, TUNE_JINGLE, 7'h7F, 16'd0, 16'hFFFF);

    // A length above the RAM size is clipped to it.
    wait_idle();
    write_length(8'hFF);
    send_item(FUNC_START, TUNE_RAM, 7'd0, 16'd0, 16'd0);
    repeat (4) send_item(FUNC_NEXT, TUNE_RAM, 7'd0, 16'd0, 16'd0);

    while (items_sent < ItemTarget) begin
      wait_idle();
      case ($urandom_range(0, 9))
        0:       cur_len = 8'd0;
        1:       cur_len = 8'd1;
        2:       cur_len = 8'd128;
        3:       cur_len = 8'hFF;
        4:       cur_len = 8'($urandom_range(129, 254));
        5:       cur_len = 8'($urandom);
        default: cur_len = 8'($urandom_range(2, 12));
      endcase
      write_length(cur_len);
      eff_len = (cur_len > 8'd128) ? 128 : int'(cur_len);
      idle_phase = ($urandom_range(0, 2) != 0);
      phase_end = items_sent + PhaseItems;
      while (items_sent < phase_end && items_sent < ItemTarget) begin
        case ($urandom_range(0, 9))
          0, 1, 2: begin
            // Upload the RAM tune from slot zero, then play it out.
            n_notes = (eff_len > 0 && eff_len <= 20) ? eff_len : $urandom_range(1, 20);
            for (int i = 0; i < n_notes; i++) begin
              send_item(FUNC_STORE, 3'($urandom), 7'(i), pick_freq(), pick_ms());
            end
            send_item(FUNC_START, TUNE_RAM, 7'($urandom), 16'($urandom), 16'($urandom));
            if (eff_len <= 40 || $urandom_range(0, 2) == 0) begin
              plays = eff_len + $urandom_range(0, 2);
            end else begin
              plays = $urandom_range(1, 30);
            end
            repeat (plays) begin
              send_item(FUNC_NEXT, 3'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
            end
          end
          3, 4, 5: begin
            // Play a fixed tune, often past its end.
            send_item(FUNC_START, 3'($urandom_range(0, 4)), 7'($urandom), 16'($urandom),
                      16'($urandom));
            repeat ($urandom_range(1, 13)) begin
              send_item(FUNC_NEXT, 3'($urandom), 7'($urandom), 16'($urandom), 16'($urandom));
            end
          end
          6: begin
            send_item(FUNC_STORE, 3'($urandom), 7'($urandom), pick_freq(), pick_ms());
          end
          default: begin
            // Noise: any function code with any fields.
            send_item(2'($urandom), 3'($urandom), 7'($urandom), pick_freq(), pick_ms());
          end
        endcase
      end
    end

    wait_idle();
    repeat (DrainCycles) @(posedge clk_i);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
